/* src/bm25idf_pkg.sv */
// shared constants for the bm25 idf block: fixed-point log format, ln2 scale, port widths
// no dependencies; imported by the top level and the port checker
package bm25idf_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // guard bits kept below the output fraction during the log2 iteration
  localparam int LOG_GUARD = 4;
  // mantissa format q1.30
  localparam int MANT_BITS = 30;
  // ln2 in q0.24, and the matching shift back to the output scale
  localparam int LN2_FRAC  = 24;
  localparam int LN_SHIFT  = LOG_GUARD + LN2_FRAC;
  localparam logic [LN2_FRAC-1:0] LN2_Q24 = 24'd11629080;

  localparam int IN_TDATA_W  = 32;
  localparam int CFG_W       = 32;
  localparam int OUT_W       = 21;
  localparam int OUT_TDATA_W = 48;

endpackage

/* src/bm25_idf_with_subterm_correction_top.sv */
// bm25 idf with subexpression correction: top level, sequencer and shared multiplier
// depends on bm25idf_pkg; port checker attached by bind in bm25idf_chk.sv
//
// A group of document-match counts arrives on the s_axis side: the expression's own count
// first (s_axis_tuser = 1), then its subexpression counts, the final one marked by
// s_axis_tlast. Counts that do not end a group are taken one per cycle. The final count
// starts the computation, and s_axis_tready stays low until it is done: one result request
// then appears on m_axis with idf = ln((N-n+0.5)/(n+0.5)) and the corrected idf (idf minus
// the idf of the largest count of the group, clamped at zero), both unsigned Q5.16, with
// m_axis_tuser = 1 when N > 2n and both values zero otherwise. Each log is taken as
// log2(2x+1) by one normalize pass and one squaring per fraction bit on a single shared
// 31x31 multiplier; the same multiplier then scales by ln2. A scored final count with
// largest count <= N needs four logs and, unless the correction comes out zero, a second
// ln2 scaling; with the largest count above N only two logs are needed, and an unscored
// count needs none. The result waits while a previous result still sits unread in the
// output register. A finished result waits in the output register while the next counts
// are taken. collection_docs (N) is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
module bm25_idf_with_subterm_correction_top
  import bm25idf_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: collection_docs
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  // input requests
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] match_count
  input  logic                   s_axis_tuser,   // first_of_group
  input  logic                   s_axis_tlast,   // last_of_group
  // result requests
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [20:0] idf_value, [41:21] idf_corrected
  output logic                   m_axis_tuser    // scored
);

  localparam int CW       = COUNT_BITS;
  localparam int XW       = CW + 1;                   // width of 2x+1
  localparam int EW       = $clog2(XW);               // exponent / shift width
  localparam int LOG_FRAC = FRAC_BITS + LOG_GUARD;
  localparam int LW       = EW + LOG_FRAC;            // log2 value width
  localparam int SW       = LW + 1;                   // sum of two logs
  localparam int MANT_W   = MANT_BITS + 1;
  localparam int MW       = (SW > MANT_W) ? SW : MANT_W;
  localparam int PW       = 2 * MW;
  localparam int FCW      = $clog2(LOG_FRAC);
  localparam int PAD_W    = OUT_TDATA_W - 2 * OUT_W;

  // which log the unit is working on
  localparam logic [1:0] LG_NUM    = 2'd0;  // 2(N-n)+1
  localparam logic [1:0] LG_DEN    = 2'd1;  // 2n+1
  localparam logic [1:0] LG_SUB    = 2'd2;  // 2m+1
  localparam logic [1:0] LG_SUBNUM = 2'd3;  // 2(N-m)+1

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_NORM, S_SQR, S_IDF_MUL, S_IDF_WR, S_COR_MUL, S_COR_WR, S_DONE
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   collection_docs;
  logic [CW-1:0]      own_count;
  logic [CW-1:0]      largest_sub_count;
  logic               do_sub;
  logic [1:0]         sel;
  logic [XW-1:0]      xr;
  logic [EW-1:0]      sh;
  logic [EW-1:0]      z;
  logic [MANT_W-1:0]  mant;
  logic [LOG_FRAC-1:0] frac;
  logic [FCW-1:0]     iter;
  logic [LW-1:0]      lg [4];
  logic [PW-1:0]      prod;
  logic [OUT_W-1:0]   idf_r;
  logic [OUT_W-1:0]   corr_r;
  logic               scored_r;
  logic [OUT_W-1:0]   out_idf;
  logic [OUT_W-1:0]   out_corr;
  logic               out_scored;

  // input and register truncated / extended to the count width
  logic [CW+IN_TDATA_W-1:0] cnt_wide;
  logic [CW+CFG_W-1:0]      n_wide;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            big_n;
  logic                     in_acc;

  assign cnt_wide = {{CW{1'b0}}, s_axis_tdata};
  assign n_wide   = {{CW{1'b0}}, collection_docs};
  assign cnt      = cnt_wide[CW-1:0];
  assign big_n    = n_wide[CW-1:0];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // operand of the next log
  logic [1:0]    op_idx;
  logic [CW-1:0] op_base;
  logic [XW-1:0] op_x;

  always_comb begin
    op_idx = (state == S_CHECK) ? LG_NUM : sel + 2'd1;
    unique case (op_idx)
      LG_NUM:    op_base = big_n - own_count;
      LG_DEN:    op_base = own_count;
      LG_SUB:    op_base = largest_sub_count;
      LG_SUBNUM: op_base = big_n - largest_sub_count;
      default:   op_base = own_count;
    endcase
    op_x = {op_base, 1'b1};
  end

  // normalize step: shift by sh when the top sh bits are clear
  logic [XW-1:0]        hi_mask;
  logic                 top_zero;
  logic [XW-1:0]        xn;
  logic [EW-1:0]        z_next;
  logic [XW+MANT_W-1:0] mant_wide;
  logic [EW-1:0]        e_val;

  assign hi_mask   = ~({XW{1'b1}} >> sh);
  assign top_zero  = (xr & hi_mask) == '0;
  assign xn        = top_zero ? (xr << sh) : xr;
  assign z_next    = top_zero ? (z + sh) : z;
  assign mant_wide = {xn, {MANT_W{1'b0}}};
  assign e_val     = EW'(XW - 1) - z;

  // log differences
  logic [LW-1:0] idf_d;
  logic [SW-1:0] sum_a;
  logic [SW-1:0] sum_b;

  assign idf_d = lg[0] - lg[1];
  assign sum_a = SW'(lg[0]) + SW'(lg[2]);
  assign sum_b = SW'(lg[1]) + SW'(lg[3]);

  // shared multiplier: squaring of the mantissa, or scaling by ln2
  logic [MW-1:0]     mul_a;
  logic [MW-1:0]     mul_b;
  logic [PW-1:0]     mul_p;
  logic              sq_hi;
  logic [MANT_W-1:0] mant_sq;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQR: begin
        mul_a = MW'(mant);
        mul_b = MW'(mant);
      end
      S_IDF_MUL: begin
        mul_a = MW'(idf_d);
        mul_b = MW'(LN2_Q24);
      end
      S_COR_MUL: begin
        mul_a = MW'(sum_a - sum_b);
        mul_b = MW'(LN2_Q24);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign sq_hi   = mul_p[2*MANT_BITS+1];
  assign mant_sq = sq_hi ? mul_p[2*MANT_BITS+1 -: MANT_W] : mul_p[2*MANT_BITS -: MANT_W];

  // round half up to the output scale, saturate
  function automatic logic [OUT_W-1:0] to_ln(input logic [PW-1:0] p);
    logic [PW:0] r;
    r = {1'b0, p} + ((PW+1)'(1) << (LN_SHIFT - 1));
    if (|r[PW:LN_SHIFT+OUT_W]) return {OUT_W{1'b1}};
    return r[LN_SHIFT+OUT_W-1:LN_SHIFT];
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_corr, out_idf};
  assign m_axis_tuser  = out_scored;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      collection_docs   <= '0;
      own_count         <= '0;
      largest_sub_count <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        collection_docs <= cfg_wr_data;
      end
      // a taken result frees the register unless the next one loads right now
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              own_count         <= cnt;
              largest_sub_count <= cnt;
            end else if (cnt > largest_sub_count) begin
              largest_sub_count <= cnt;
            end
            if (s_axis_tlast) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          do_sub <= largest_sub_count <= big_n;
          if ({1'b0, big_n} > {own_count, 1'b0}) begin
            scored_r <= 1'b1;
            sel      <= LG_NUM;
            xr       <= op_x;
            z        <= '0;
            sh       <= EW'(1) << (EW - 1);
            state    <= S_NORM;
          end else begin
            scored_r <= 1'b0;
            idf_r    <= '0;
            corr_r   <= '0;
            state    <= S_DONE;
          end
        end
        S_NORM: begin
          xr <= xn;
          z  <= z_next;
          sh <= sh >> 1;
          if (sh == EW'(1)) begin
            mant  <= mant_wide[XW+MANT_W-1 -: MANT_W];
            iter  <= FCW'(LOG_FRAC - 1);
            state <= S_SQR;
          end
        end
        S_SQR: begin
          mant <= mant_sq;
          frac <= {frac[LOG_FRAC-2:0], sq_hi};
          iter <= iter - FCW'(1);
          if (iter == '0) begin
            lg[sel] <= {e_val, frac[LOG_FRAC-2:0], sq_hi};
            if (sel == LG_SUBNUM || (sel == LG_DEN && !do_sub)) begin
              state <= S_IDF_MUL;
            end else begin
              sel   <= op_idx;
              xr    <= op_x;
              z     <= '0;
              sh    <= EW'(1) << (EW - 1);
              state <= S_NORM;
            end
          end
        end
        S_IDF_MUL: begin
          prod  <= mul_p;
          state <= S_IDF_WR;
        end
        S_IDF_WR: begin
          idf_r <= to_ln(prod);
          if (do_sub && sum_a > sum_b) begin
            state <= S_COR_MUL;
          end else begin
            corr_r <= '0;
            state  <= S_DONE;
          end
        end
        S_COR_MUL: begin
          prod  <= mul_p;
          state <= S_COR_WR;
        end
        S_COR_WR: begin
          corr_r <= to_ln(prod);
          state  <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            out_idf       <= idf_r;
            out_corr      <= corr_r;
            out_scored    <= scored_r;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/bm25idf_chk.sv */
// port checker for the bm25 idf block, attached to the top level by bind
// depends on bm25idf_pkg
module bm25idf_chk
  import bm25idf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result request pending after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result request changed");

  // unscored result carries zero values
  a_unscored_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2*OUT_W-1:0] == '0)
    else $error("unscored result with nonzero idf");

  // counts inside a group never stall the input
  a_mid_group: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
    else $error("input stalled after a count inside a group");

  // the final count starts the computation
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input ready right after the final count of a group");

endmodule

bind bm25_idf_with_subterm_correction_top bm25idf_chk u_bm25idf_chk (.*);

/* tb/bm25idf_checker.sv */
// result checker for the bm25 idf block: follows the request and result channels,
// predicts each result from the accepted counts and the collection size, compares them
// depends on bm25idf_pkg for the fixed-point format and the port widths
module bm25idf_checker
  import bm25idf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   done,
  output int                     errors,
  output int                     pending,
  output int                     results
);

  localparam int LOG_FRAC = FRAC_BITS_DEF + LOG_GUARD;
  localparam logic [63:0] OUT_MAX = (64'd1 << OUT_W) - 64'd1;

  typedef struct packed {
    logic [OUT_W-1:0] idf;
    logic [OUT_W-1:0] corr;
    logic             scored;
  } idf_result_t;

  idf_result_t idf_expected_q[$];
  logic [31:0] docs_n;
  logic [31:0] own_cnt;
  logic [31:0] largest_cnt;
  int          err_cnt;
  int          res_cnt;
  bit          done_seen;

  initial begin
    err_cnt = 0;
    res_cnt = 0;
    done_seen = 1'b0;
  end

  // log2 of x >= 1 in q.20, squaring one fraction bit at a time
  function automatic logic [63:0] log2_q(input logic [63:0] x);
    logic [63:0] mant;
    logic [63:0] frac;
    int          e;
    e    = 0;
    frac = '0;
    if (x == 0) return '0;
    for (int b = 0; b < 64; b++) if (x[b]) e = b;
    if (e >= MANT_BITS) mant = x >> (e - MANT_BITS);
    else mant = x << (MANT_BITS - e);
    for (int i = 0; i < LOG_FRAC; i++) begin
      mant = (mant * mant) >> MANT_BITS;
      frac = frac << 1;
      if (mant >= (64'd2 << MANT_BITS)) begin
        frac[0] = 1'b1;
        mant    = mant >> 1;
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  // log2 difference to natural log q.16, round half up, saturate
  function automatic logic [OUT_W-1:0] ln_q16(input logic [63:0] d);
    logic [63:0] r;
    r = (d * 64'(LN2_Q24) + (64'd1 << (LN_SHIFT - 1))) >> LN_SHIFT;
    if (r > OUT_MAX) r = OUT_MAX;
    return r[OUT_W-1:0];
  endfunction

  function automatic idf_result_t predict_idf(input logic [63:0] n, input logic [63:0] m,
                                              input logic [63:0] docs);
    idf_result_t r;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] a;
    logic [63:0] b;
    r = '0;
    if (docs > 64'd2 * n) begin
      num      = log2_q(64'd2 * (docs - n) + 64'd1);
      den      = log2_q(64'd2 * n + 64'd1);
      r.scored = 1'b1;
      r.idf    = ln_q16(num - den);
      // largest count above N leaves the correction at zero
      if (m <= docs) begin
        a = num + log2_q(64'd2 * m + 64'd1);
        b = den + log2_q(64'd2 * (docs - m) + 64'd1);
        if (a > b) r.corr = ln_q16(a - b);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("checker: mismatch %s", what);
  endtask

  always @(posedge clk) begin
    idf_result_t got;
    idf_result_t want;
    if (rst) begin
      idf_expected_q.delete();
      docs_n      = '0;
      own_cnt     = '0;
      largest_cnt = '0;
    end else begin
      if (cfg_wr_en) docs_n = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got.idf    = m_axis_tdata[OUT_W-1:0];
        got.corr   = m_axis_tdata[2*OUT_W-1:OUT_W];
        got.scored = m_axis_tuser;
        res_cnt++;
        if (idf_expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", res_cnt));
        end else begin
          want = idf_expected_q.pop_front();
          if (got.idf !== want.idf)
            report_mismatch($sformatf("result %0d idf got %0d want %0d",
                                      res_cnt, got.idf, want.idf));
          if (got.corr !== want.corr)
            report_mismatch($sformatf("result %0d corrected got %0d want %0d",
                                      res_cnt, got.corr, want.corr));
          if (got.scored !== want.scored)
            report_mismatch($sformatf("result %0d scored got %0b want %0b",
                                      res_cnt, got.scored, want.scored));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          own_cnt     = s_axis_tdata;
          largest_cnt = s_axis_tdata;
        end else if (s_axis_tdata > largest_cnt) begin
          largest_cnt = s_axis_tdata;
        end
        if (s_axis_tlast)
          idf_expected_q.push_back(predict_idf(64'(own_cnt), 64'(largest_cnt),
                                               64'(docs_n)));
      end
    end
    if (done && !done_seen) begin
      done_seen = 1'b1;
      if (idf_expected_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", idf_expected_q.size()));
    end
    errors  <= err_cnt;
    pending <= idf_expected_q.size();
    results <= res_cnt;
  end

endmodule

/* tb/tb.sv */
// top of the bm25 idf testbench: clock, reset, count requests, result back-pressure
// depends on bm25idf_pkg, bm25_idf_with_subterm_correction_top and bm25idf_checker
module tb;
  import bm25idf_pkg::*;

  // generous bound on the whole run, several times the slowest legal run
  localparam int CYCLE_LIMIT   = 1000000;
  // cycles to let an in-flight computation drain before a register write
  localparam int DRAIN_CYCLES  = 150;
  localparam int PHASE_REQS    = 205;
  localparam int NUM_PHASES    = 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] match_count
  logic                   s_axis_tuser = 1'b0; // first_of_group
  logic                   s_axis_tlast = 1'b0; // last_of_group
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [20:0] idf_value, [41:21] idf_corrected
  logic                   m_axis_tuser;        // scored
  logic                   done = 1'b0;

  int errors;
  int pending;
  int results;
  int cycles = 0;
  int reqs_sent = 0;
  int docs_writes = 0;
  bit no_idle = 1'b0;
  logic [31:0] cur_docs = '0;

  always #10 clk = ~clk;

  bm25_idf_with_subterm_correction_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bm25idf_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .done          (done),
    .errors        (errors),
    .pending       (pending),
    .results       (results)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side back-pressure, stalls about a quarter of the cycles unless in a quiet phase
  always @(posedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 26);
  end

  // one count request; tvalid stays high into the next call unless an idle gap comes first
  task automatic send_count(input logic [31:0] cnt, input logic first, input logic last);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 26) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cnt;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    reqs_sent++;
  endtask

  // hold off requests until every expected result has been taken
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // new collection size, only written while the block is idle
  task automatic set_docs(input logic [31:0] docs);
    drain_results();
    // a trailing count that ended no group may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= docs;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_docs = docs;
    docs_writes++;
  endtask

  // counts spread around the interesting ranges for the current collection size
  function automatic logic [31:0] pick_count(input logic [31:0] docs);
    logic [31:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = $urandom_range(0, docs >> 1);
      3, 4:    c = $urandom_range(0, docs);
      5:       c = $urandom_range(docs >> 1, docs);
      6:       c = $urandom_range(0, 15);
      7, 8:    c = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       c = '0;
          1:       c = '1;
          2:       c = docs;
          default: c = docs >> 1;
        endcase
      end
    endcase
    return c;
  endfunction

  initial begin
    int          sent;
    int          subs;
    logic [31:0] own;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, mid-size collection
    set_docs(32'd1000);
    // continuation without a start right after reset: open group has zero own count
    send_count(32'd300, 1'b0, 1'b0);
    send_count(32'd10, 1'b0, 1'b1);
    // one-item group
    send_count(32'd100, 1'b1, 1'b1);
    // ordinary group, largest sub count below N/2
    send_count(32'd100, 1'b1, 1'b0);
    send_count(32'd50, 1'b0, 1'b0);
    send_count(32'd400, 1'b0, 1'b1);
    // largest count between N/2 and N: negative sub idf
    send_count(32'd10, 1'b1, 1'b0);
    send_count(32'd700, 1'b0, 1'b1);
    // largest count above N: no correction
    send_count(32'd10, 1'b1, 1'b0);
    send_count(32'd5000, 1'b0, 1'b1);
    // scoring boundary N == 2n and just below
    send_count(32'd500, 1'b1, 1'b1);
    send_count(32'd499, 1'b1, 1'b1);
    send_count(32'd0, 1'b1, 1'b1);
    send_count(32'd1, 1'b1, 1'b0);
    send_count(32'hFFFF_FFFF, 1'b0, 1'b1);

    // largest collection size
    set_docs(32'hFFFF_FFFF);
    send_count(32'd0, 1'b1, 1'b1);
    // corrected value overflows and saturates
    send_count(32'd0, 1'b1, 1'b0);
    send_count(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_count(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_count(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_count(32'hFFFF_FFFF, 1'b0, 1'b1);

    // empty collection, then a single document
    set_docs(32'd0);
    send_count(32'd0, 1'b1, 1'b1);
    set_docs(32'd1);
    send_count(32'd0, 1'b1, 1'b0);
    send_count(32'd1, 1'b0, 1'b1);

    // random part: one collection size per phase, mostly well-formed groups
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_docs(32'hFFFF_FFFF);
        1:       set_docs($urandom_range(1, 200));
        2:       set_docs($urandom);
        3:       set_docs($urandom_range(1000, 100000));
        4:       set_docs(32'd1);
        5:       set_docs($urandom);
        6:       set_docs($urandom_range(2, 20));
        default: set_docs(32'h8000_0000);
      endcase
      // one phase runs with no idling on either side
      no_idle <= (ph == 3);
      sent = 0;
      while (sent < PHASE_REQS) begin
        // mid-phase hold-off until all results are back
        if (ph == 5 && sent >= PHASE_REQS / 2 && sent < PHASE_REQS / 2 + 6) begin
          drain_results();
          sent = PHASE_REQS / 2 + 6;
        end
        if ($urandom_range(0, 99) < 85) begin
          // well-formed group: own count first, then sub counts, last one marked
          subs = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          own  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, cur_docs >> 1)
                                            : pick_count(cur_docs);
          send_count(own, 1'b1, subs == 0);
          for (int k = 0; k < subs; k++) send_count(pick_count(cur_docs), 1'b0, k == subs - 1);
          sent += subs + 1;
        end else begin
          // noise: stray marks, continuations without a start, repeated starts
          send_count(pick_count(cur_docs), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
    no_idle <= 1'b0;

    // end of run: wait for the remaining results, then let the block settle
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("tb: %0d count requests over %0d collection sizes, %0d results checked",
             reqs_sent, docs_writes, results);
    $display("tb: groups, stray marks, unscored and saturating cases, %0d cycles", cycles);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
